### src/source_byte_tokenizer_core_macros.svh
// Assertion macros shared by the tokenizer checker.
// No dependencies; included by sbt_checker.sv.
`ifndef SOURCE_BYTE_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_BYTE_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SBT_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SBT_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sbt_pkg.sv
// Shared types, widths, token kinds and keyword tables of the byte tokenizer.
// No dependencies; used by every other file but the macros header.
package sbt_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 24;

    // Token kinds
    localparam logic [4:0] KIND_IDENT     = 5'd0;
    localparam logic [4:0] KIND_KW_BASE   = 5'd1;
    localparam logic [4:0] KIND_INT       = 5'd8;
    localparam logic [4:0] KIND_FLOAT     = 5'd9;
    localparam logic [4:0] KIND_LPAREN    = 5'd10;
    localparam logic [4:0] KIND_RPAREN    = 5'd11;
    localparam logic [4:0] KIND_ASSIGN    = 5'd12;
    localparam logic [4:0] KIND_AMP       = 5'd13;
    localparam logic [4:0] KIND_PIPE      = 5'd14;
    localparam logic [4:0] KIND_OP_BASE   = 5'd15;
    localparam logic [4:0] KIND_OP_LAST   = 5'd28;
    localparam logic [4:0] KIND_LINEBREAK = 5'd29;
    localparam logic [4:0] KIND_EOF       = 5'd30;
    localparam logic [4:0] KIND_ERROR     = 5'd31;

    // Error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED  = 2'd1;
    localparam logic [1:0] ERR_NO_FRACTION = 2'd2;

    // Keywords: do, else, for, function, if, return, while
    localparam int NUM_KW = 7;
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd2, 4'd4, 4'd3, 4'd8, 4'd2, 4'd6, 4'd5};

    // Operators that may take a trailing '='
    localparam int NUM_OPS = 7;
    localparam logic [7:0] OP_CHARS [NUM_OPS] = '{"+", "-", "*", "/", "%", ">", "<"};

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LENGTH_BITS-1:0] length_t;
    typedef logic [LINE_BITS-1:0]   line_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [1:0] err;
        offset_t    offset;
        length_t    length;
        line_t      line;
        logic       last;
    } token_t;

    // Up to two tokens caused by one byte
    typedef struct packed {
        token_t     first;
        token_t     second;
        logic [1:0] count;
    } batch_t;

endpackage

### src/sbt_if.sv
// Handshake channels of the tokenizer: source bytes in, tokens out.
// Depends on sbt_pkg for field widths.
interface sbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

interface sbt_token_if;
    logic                 valid;
    logic                 ready;
    logic [4:0]           token_kind;
    logic [1:0]           error_code;
    sbt_pkg::offset_t     token_offset;
    sbt_pkg::length_t     token_length;
    sbt_pkg::line_t       token_line;
    logic                 last_of_run;

    modport source (output valid, output token_kind, output error_code, output token_offset,
                    output token_length, output token_line, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input error_code, input token_offset,
                  input token_length, input token_line, input last_of_run,
                  output ready);
endinterface

### src/sbt_scanner.sv
// Scanner state and per-byte next-state logic; forms up to two tokens per byte.
// Depends on sbt_pkg.
module sbt_scanner
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      source_byte,
    output sbt_pkg::batch_t batch
);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_INT   = 3'd2;
    localparam logic [2:0] MODE_ZERO  = 3'd3;
    localparam logic [2:0] MODE_DOT   = 3'd4;
    localparam logic [2:0] MODE_FRAC  = 3'd5;
    localparam logic [2:0] MODE_OPER  = 3'd6;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PIPE    = 8'h7C;

    localparam sbt_pkg::length_t LEN_MAX  = '1;
    localparam sbt_pkg::line_t   LINE_MAX = '1;
    localparam logic [sbt_pkg::NUM_KW-1:0] KW_ALL = '1;

    logic [2:0]                     mode_reg, mode_next;
    logic [2:0]                     op_reg, op_next;
    logic [sbt_pkg::NUM_KW-1:0]     kw_reg, kw_next;
    sbt_pkg::offset_t               start_reg, start_next;
    sbt_pkg::offset_t               cur_reg, cur_next;
    sbt_pkg::length_t               len_reg, len_next;
    sbt_pkg::line_t                 line_reg, line_next;

    logic                           ch_letter, ch_numeral, taken, op_hit;
    logic [2:0]                     op_idx;
    sbt_pkg::length_t               len_grow;
    logic                           flush_valid, new_valid;
    sbt_pkg::token_t                flush_tok, new_tok;
    logic [4:0]                     ident_kind;

    // Drop keywords that cannot match at position pos
    function automatic logic [sbt_pkg::NUM_KW-1:0] kw_narrow(
        input logic [sbt_pkg::NUM_KW-1:0] kw,
        input sbt_pkg::length_t           pos,
        input logic [7:0]                 ch
    );
        logic [sbt_pkg::NUM_KW-1:0] res;
        res = kw;
        for (int i = 0; i < sbt_pkg::NUM_KW; i++)
        begin
            if (pos >= sbt_pkg::LENGTH_BITS'(sbt_pkg::KW_LEN[i]) ||
                sbt_pkg::KW_TEXT[i][pos[2:0]] != ch)
            begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    // Character classes
    assign ch_letter  = source_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
    assign ch_numeral = source_byte inside {[8'h30:8'h39]};
    assign len_grow = (len_reg == LEN_MAX) ? len_reg : len_reg + sbt_pkg::LENGTH_BITS'(1);

    // Operator lookup
    always_comb
    begin
        op_hit = 1'b0;
        op_idx = 3'd0;
        for (int i = 0; i < sbt_pkg::NUM_OPS; i++)
        begin
            if (source_byte == sbt_pkg::OP_CHARS[i])
            begin
                op_hit = 1'b1;
                op_idx = 3'(i);
            end
        end
    end

    // Keyword resolution of a finished identifier; later entries win
    always_comb
    begin
        ident_kind = sbt_pkg::KIND_IDENT;
        for (int i = 0; i < sbt_pkg::NUM_KW; i++)
        begin
            if (kw_reg[i] && len_reg == sbt_pkg::LENGTH_BITS'(sbt_pkg::KW_LEN[i]))
            begin
                ident_kind = sbt_pkg::KIND_KW_BASE + 5'(i);
            end
        end
    end

    // Next state and emitted tokens
    always_comb
    begin
        mode_next   = mode_reg;
        op_next     = op_reg;
        kw_next     = kw_reg;
        start_next  = start_reg;
        cur_next    = cur_reg + sbt_pkg::OFFSET_BITS'(1);
        len_next    = len_reg;
        line_next   = line_reg;
        taken       = 1'b0;
        flush_valid = 1'b0;
        new_valid   = 1'b0;
        flush_tok   = '{kind: sbt_pkg::KIND_IDENT, err: sbt_pkg::ERR_NONE, offset: start_reg,
                        length: len_reg, line: line_reg, last: 1'b0};
        new_tok     = '{kind: sbt_pkg::KIND_ERROR, err: sbt_pkg::ERR_NONE, offset: cur_reg,
                        length: sbt_pkg::LENGTH_BITS'(1), line: line_reg, last: 1'b0};

        // Extend the pending token
        case (mode_reg)
            MODE_IDENT:
            begin
                if (ch_letter || ch_numeral)
                begin
                    taken    = 1'b1;
                    kw_next  = kw_narrow(kw_reg, len_reg, source_byte);
                    len_next = len_grow;
                end
            end
            MODE_INT:
            begin
                if (ch_numeral)
                begin
                    taken    = 1'b1;
                    len_next = len_grow;
                end
                else if (source_byte == CH_DOT)
                begin
                    taken     = 1'b1;
                    mode_next = MODE_DOT;
                    len_next  = len_grow;
                end
            end
            MODE_ZERO:
            begin
                if (source_byte == CH_DOT)
                begin
                    taken     = 1'b1;
                    mode_next = MODE_DOT;
                    len_next  = len_grow;
                end
            end
            MODE_DOT, MODE_FRAC:
            begin
                if (ch_numeral)
                begin
                    taken     = 1'b1;
                    mode_next = MODE_FRAC;
                    len_next  = len_grow;
                end
            end
            MODE_OPER:
            begin
                if (source_byte == CH_EQUAL)
                begin
                    taken          = 1'b1;
                    mode_next      = MODE_IDLE;
                    len_next       = len_grow;
                    new_valid      = 1'b1;
                    new_tok.kind   = sbt_pkg::KIND_OP_BASE + {1'b0, op_reg, 1'b1};
                    new_tok.offset = start_reg;
                    new_tok.length = len_grow;
                end
            end
            default:
            begin
            end
        endcase

        if (!taken)
        begin
            // Flush the pending token
            flush_valid = 1'b1;
            case (mode_reg)
                MODE_IDENT:            flush_tok.kind = ident_kind;
                MODE_INT, MODE_ZERO:   flush_tok.kind = sbt_pkg::KIND_INT;
                MODE_FRAC:             flush_tok.kind = sbt_pkg::KIND_FLOAT;
                MODE_DOT:
                begin
                    flush_tok.kind = sbt_pkg::KIND_ERROR;
                    flush_tok.err  = sbt_pkg::ERR_NO_FRACTION;
                end
                MODE_OPER:
                begin
                    flush_tok.kind = sbt_pkg::KIND_OP_BASE + {1'b0, op_reg, 1'b0};
                end
                default:               flush_valid = 1'b0;
            endcase
            mode_next = MODE_IDLE;

            // Scan the byte afresh
            if (source_byte == CH_NUL)
            begin
                new_valid      = 1'b1;
                new_tok.kind   = sbt_pkg::KIND_EOF;
                new_tok.length = '0;
                op_next        = 3'd0;
                kw_next        = KW_ALL;
                start_next     = '0;
                cur_next       = '0;
                len_next       = '0;
                line_next      = sbt_pkg::LINE_BITS'(1);
            end
            else if (source_byte inside {CH_SPACE, CH_TAB, CH_CR})
            begin
            end
            else if (ch_letter)
            begin
                mode_next  = MODE_IDENT;
                start_next = cur_reg;
                kw_next    = kw_narrow(KW_ALL, '0, source_byte);
                len_next   = sbt_pkg::LENGTH_BITS'(1);
            end
            else if (ch_numeral)
            begin
                mode_next  = (source_byte == CH_ZERO) ? MODE_ZERO : MODE_INT;
                start_next = cur_reg;
                len_next   = sbt_pkg::LENGTH_BITS'(1);
            end
            else if (source_byte == CH_LF)
            begin
                line_next    = (line_reg == LINE_MAX) ? line_reg
                                                      : line_reg + sbt_pkg::LINE_BITS'(1);
                new_valid    = 1'b1;
                new_tok.kind = sbt_pkg::KIND_LINEBREAK;
                new_tok.line = line_next;
            end
            else if (source_byte == CH_LPAREN)
            begin
                new_valid    = 1'b1;
                new_tok.kind = sbt_pkg::KIND_LPAREN;
            end
            else if (source_byte == CH_RPAREN)
            begin
                new_valid    = 1'b1;
                new_tok.kind = sbt_pkg::KIND_RPAREN;
            end
            else if (source_byte == CH_EQUAL)
            begin
                new_valid    = 1'b1;
                new_tok.kind = sbt_pkg::KIND_ASSIGN;
            end
            else if (source_byte == CH_AMP)
            begin
                new_valid    = 1'b1;
                new_tok.kind = sbt_pkg::KIND_AMP;
            end
            else if (source_byte == CH_PIPE)
            begin
                new_valid    = 1'b1;
                new_tok.kind = sbt_pkg::KIND_PIPE;
            end
            else if (op_hit)
            begin
                mode_next  = MODE_OPER;
                op_next    = op_idx;
                start_next = cur_reg;
                len_next   = sbt_pkg::LENGTH_BITS'(1);
            end
            else
            begin
                new_valid    = 1'b1;
                new_tok.err  = sbt_pkg::ERR_UNEXPECTED;
            end
        end
    end

    // Pack tokens in order; the final one carries last
    always_comb
    begin
        batch.first  = flush_valid ? flush_tok : new_tok;
        batch.second = new_tok;
        batch.count  = {1'b0, flush_valid} + {1'b0, new_valid};
        batch.second.last = 1'b1;
        batch.first.last  = !(flush_valid && new_valid);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            op_reg    <= 3'd0;
            kw_reg    <= KW_ALL;
            start_reg <= '0;
            cur_reg   <= '0;
            len_reg   <= '0;
            line_reg  <= sbt_pkg::LINE_BITS'(1);
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            op_reg    <= op_next;
            kw_reg    <= kw_next;
            start_reg <= start_next;
            cur_reg   <= cur_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
        end
    end

endmodule

### src/sbt_out_stage.sv
// Result register pair and output register; hands tokens out one per word.
// Depends on sbt_pkg.
module sbt_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_ready,
    output logic            accept,
    input  sbt_pkg::batch_t batch,
    output logic            tok_valid,
    input  logic            tok_ready,
    output sbt_pkg::token_t tok
);

    sbt_pkg::token_t slot0_reg, slot0_next;
    sbt_pkg::token_t slot1_reg, slot1_next;
    logic [1:0]      cnt_reg, cnt_next;
    sbt_pkg::token_t tok_reg, tok_next;
    logic            tok_valid_reg, tok_valid_next;
    logic            o_load, pop;

    // Room check: the pair must be empty after this cycle's pop
    always_comb
    begin
        o_load     = !tok_valid_reg || tok_ready;
        pop        = o_load && (cnt_reg != 2'd0);
        byte_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && o_load);
        accept     = byte_valid && byte_ready;
    end

    // Move one token to the output register, refill the pair
    always_comb
    begin
        slot0_next     = slot0_reg;
        slot1_next     = slot1_reg;
        cnt_next       = cnt_reg;
        tok_next       = tok_reg;
        tok_valid_next = o_load ? pop : tok_valid_reg;
        if (pop)
        begin
            tok_next   = slot0_reg;
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (accept)
        begin
            slot0_next = batch.first;
            slot1_next = batch.second;
            cnt_next   = batch.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 2'd0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        tok_reg   <= tok_next;
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

### src/source_byte_tokenizer_core.sv
// A token passes from the accepted byte through the result register pair into the output register.
// Throughput: one byte per cycle while the output is not stalled; a byte that yields two tokens
// (a flushed token plus its own) holds the input until its first token is in the single-word output register.
// Reset (rst_n low, asynchronous): offset 0, line 1, no pending token, output empty.
// Depends on sbt_pkg, sbt_if, sbt_scanner and sbt_out_stage.
module source_byte_tokenizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    sbt_byte_if.sink    bytes,
    sbt_token_if.source tokens
);

    sbt_pkg::batch_t batch;
    sbt_pkg::token_t tok;
    logic            accept;
    logic            byte_ready;
    logic            tok_valid;

    // Per-byte scan
    sbt_scanner u_scanner
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .source_byte (bytes.source_byte),
        .batch       (batch)
    );

    // Token buffering and output
    sbt_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (bytes.valid),
        .byte_ready (byte_ready),
        .accept     (accept),
        .batch      (batch),
        .tok_valid  (tok_valid),
        .tok_ready  (tokens.ready),
        .tok        (tok)
    );

    assign bytes.ready         = byte_ready;
    assign tokens.valid        = tok_valid;
    assign tokens.token_kind   = tok.kind;
    assign tokens.error_code   = tok.err;
    assign tokens.token_offset = tok.offset;
    assign tokens.token_length = tok.length;
    assign tokens.token_line   = tok.line;
    assign tokens.last_of_run  = tok.last;

endmodule

### src/sbt_checker.sv
// Port-level checks of the tokenizer output, bound to the top level.
// Depends on sbt_pkg and source_byte_tokenizer_core_macros.svh.
`include "source_byte_tokenizer_core_macros.svh"

module sbt_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             tok_valid,
    input logic             tok_ready,
    input logic [4:0]       token_kind,
    input logic [1:0]       error_code,
    input sbt_pkg::offset_t token_offset,
    input sbt_pkg::length_t token_length,
    input sbt_pkg::line_t   token_line,
    input logic             last_of_run
);

    logic deliver;
    logic after_eof_reg;
    logic in_pair_reg;

    assign deliver = tok_valid && tok_ready;

    // Track what the previous delivered word was
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_eof_reg <= 1'b0;
            in_pair_reg   <= 1'b0;
        end
        else if (deliver)
        begin
            after_eof_reg <= (token_kind == sbt_pkg::KIND_EOF);
            in_pair_reg   <= !last_of_run;
        end
    end

    // A stalled word stays and holds its payload
    `SBT_ASSERT_NEXT(a_stall_hold, clk, rst_n, tok_valid && !tok_ready, tok_valid && $stable(token_kind) && $stable(error_code) && $stable(token_offset) && $stable(token_length) && $stable(token_line) && $stable(last_of_run), "token word changed while stalled")

    // The word after EOF is on line 1, or is the first line break
    `SBT_ASSERT_NOW(a_line_restart, clk, rst_n, deliver && after_eof_reg, token_line == sbt_pkg::LINE_BITS'(1) || (token_kind == sbt_pkg::KIND_LINEBREAK && token_line == sbt_pkg::LINE_BITS'(2)), "line did not restart after EOF")

    // The first of two words from one byte is a flushed pending token
    `SBT_ASSERT_NOW(a_pair_first, clk, rst_n, deliver && !last_of_run, token_kind <= sbt_pkg::KIND_FLOAT || (token_kind >= sbt_pkg::KIND_OP_BASE && token_kind <= sbt_pkg::KIND_OP_LAST) || (token_kind == sbt_pkg::KIND_ERROR && error_code == sbt_pkg::ERR_NO_FRACTION), "first word of a pair is not a flushed token")

    // The second of two words is a token that never waits for lookahead
    `SBT_ASSERT_NOW(a_pair_second, clk, rst_n, deliver && in_pair_reg, (token_kind >= sbt_pkg::KIND_LPAREN && token_kind <= sbt_pkg::KIND_PIPE) || token_kind == sbt_pkg::KIND_LINEBREAK || token_kind == sbt_pkg::KIND_EOF || (token_kind == sbt_pkg::KIND_ERROR && error_code == sbt_pkg::ERR_UNEXPECTED), "second word of a pair is a pending-type token")

endmodule

bind source_byte_tokenizer_core sbt_checker u_sbt_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .tok_valid    (tokens.valid),
    .tok_ready    (tokens.ready),
    .token_kind   (tokens.token_kind),
    .error_code   (tokens.error_code),
    .token_offset (tokens.token_offset),
    .token_length (tokens.token_length),
    .token_line   (tokens.token_line),
    .last_of_run  (tokens.last_of_run)
);

### sim/testbench.sv
// Self-checking bench for source_byte_tokenizer_core: streams source bytes, predicts each token.
// Depends on sbt_pkg (token_t, kinds, error codes) and sbt_if (byte and token channels).
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbt_pkg::*;

    localparam int NUM_KEYWORDS   = 7;
    localparam int MAX_IDLE       = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_WORDS   = 1560;
    localparam int LONG_IDENT_LEN = 60;
    localparam int MAX_PRINTED    = 40;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_ZERO, SCAN_DOT, SCAN_FRAC, SCAN_OPER
    } scan_state_t;

    typedef struct {
        logic [7:0] value;
        bit         no_gap;
        bit         wait_drain;
    } source_word_t;

    string keyword_text [NUM_KEYWORDS] = '{"do", "else", "for", "function", "if", "return",
                                           "while"};
    string op_text    = "+-*/%><";
    string punct_text = "()=&|";

    logic clk = 1'b0;
    logic rst_n;

    sbt_byte_if  byte_bus ();
    sbt_token_if token_bus ();

    source_byte_tokenizer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_bus.sink),
        .tokens (token_bus.source)
    );

    // Scanner state of the predictor
    scan_state_t            scan_state;
    logic [2:0]             held_op;
    logic [NUM_KEYWORDS-1:0] kw_alive;
    offset_t                tok_start;
    offset_t                byte_pos;
    length_t                tok_len;
    line_t                  cur_line;
    int                     step_tokens;

    source_word_t source_words [$];
    token_t       expected_tokens [$];

    int  cycle_count     = 0;
    int  cycle_limit     = 0;
    int  gapped_words    = 0;
    int  gap_left        = 0;
    int  stall_left      = 0;
    int  hold_left       = 0;
    int  hold_at         = 0;
    int  hold_words_seen = 0;
    bit  hold_done       = 1'b0;
    bit  word_taken      = 1'b0;
    int  words_in        = 0;
    int  tokens_checked  = 0;
    int  keywords_seen   = 0;
    int  floats_seen     = 0;
    int  errors_seen     = 0;
    int  eofs_seen       = 0;
    int  mismatch_count  = 0;

    always #2 clk = ~clk;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == CHAR_TAB || c == CHAR_CR;
    endfunction

    // ---------------------------------------------------------------- predictor

    task automatic reset_scanner();
        scan_state = SCAN_IDLE;
        held_op    = '0;
        kw_alive   = '1;
        tok_start  = '0;
        byte_pos   = '0;
        tok_len    = '0;
        cur_line   = line_t'(1);
    endtask

    task automatic add_token(logic [4:0] kind, logic [1:0] err, offset_t offset, length_t length);
        token_t tok;
        tok.kind   = kind;
        tok.err    = err;
        tok.offset = offset;
        tok.length = length;
        tok.line   = cur_line;
        tok.last   = 1'b0;
        expected_tokens.push_back(tok);
        step_tokens++;
    endtask

    task automatic extend_token();
        if (tok_len != '1)
            tok_len++;
    endtask

    // Drop keywords that cannot match with c at the current position
    task automatic prune_keywords(logic [7:0] c);
        for (int i = 0; i < NUM_KEYWORDS; i++)
            if (tok_len >= keyword_text[i].len() || keyword_text[i][tok_len] != c)
                kw_alive[i] = 1'b0;
    endtask

    task automatic open_token(scan_state_t state, logic [7:0] c);
        scan_state = state;
        tok_start  = byte_pos;
        tok_len    = '0;
        if (state == SCAN_IDENT)
        begin
            kw_alive = '1;
            prune_keywords(c);
        end
        extend_token();
    endtask

    // Emit whatever token is held pending
    task automatic close_token();
        logic [4:0] kind;
        logic [1:0] err;
        kind = KIND_IDENT;
        err  = ERR_NONE;
        case (scan_state)
            SCAN_IDENT:
                for (int i = 0; i < NUM_KEYWORDS; i++)
                    if (kw_alive[i] && tok_len == keyword_text[i].len())
                        kind = KIND_KW_BASE + 5'(i);
            SCAN_INT, SCAN_ZERO: kind = KIND_INT;
            SCAN_DOT:
            begin
                kind = KIND_ERROR;
                err  = ERR_NO_FRACTION;
            end
            SCAN_FRAC: kind = KIND_FLOAT;
            SCAN_OPER: kind = KIND_OP_BASE + 5'(2 * held_op);
            default:   return;
        endcase
        add_token(kind, err, tok_start, tok_len);
        scan_state = SCAN_IDLE;
    endtask

    // One accepted source word: update state and queue the tokens it causes
    task automatic scan_word(logic [7:0] c);
        bit taken;
        int op_index;
        taken       = 1'b0;
        op_index    = -1;
        step_tokens = 0;

        // try to extend the pending token
        case (scan_state)
            SCAN_IDENT:
                if (is_letter(c) || is_numeral(c))
                begin
                    prune_keywords(c);
                    extend_token();
                    taken = 1'b1;
                end
            SCAN_INT:
                if (is_numeral(c))
                begin
                    extend_token();
                    taken = 1'b1;
                end
                else if (c == ".")
                begin
                    scan_state = SCAN_DOT;
                    extend_token();
                    taken = 1'b1;
                end
            SCAN_ZERO:
                if (c == ".")
                begin
                    scan_state = SCAN_DOT;
                    extend_token();
                    taken = 1'b1;
                end
            SCAN_DOT, SCAN_FRAC:
                if (is_numeral(c))
                begin
                    scan_state = SCAN_FRAC;
                    extend_token();
                    taken = 1'b1;
                end
            SCAN_OPER:
                if (c == "=")
                begin
                    extend_token();
                    add_token(KIND_OP_BASE + 5'(2 * held_op) + 5'd1, ERR_NONE, tok_start, tok_len);
                    scan_state = SCAN_IDLE;
                    taken = 1'b1;
                end
            default: ;
        endcase

        // otherwise flush it and scan the word afresh
        if (!taken)
        begin
            close_token();
            for (int i = 0; i < op_text.len(); i++)
                if (op_text[i] == c)
                    op_index = i;
            if (c == CHAR_NUL)
            begin
                add_token(KIND_EOF, ERR_NONE, byte_pos, '0);
                reset_scanner();
            end
            else if (is_blank(c))
            begin
                // blanks only separate tokens
            end
            else if (is_letter(c))
                open_token(SCAN_IDENT, c);
            else if (is_numeral(c))
                open_token(c == "0" ? SCAN_ZERO : SCAN_INT, c);
            else if (c == CHAR_LF)
            begin
                if (cur_line != '1)
                    cur_line++;
                add_token(KIND_LINEBREAK, ERR_NONE, byte_pos, length_t'(1));
            end
            else if (c == "(")
                add_token(KIND_LPAREN, ERR_NONE, byte_pos, length_t'(1));
            else if (c == ")")
                add_token(KIND_RPAREN, ERR_NONE, byte_pos, length_t'(1));
            else if (c == "=")
                add_token(KIND_ASSIGN, ERR_NONE, byte_pos, length_t'(1));
            else if (c == "&")
                add_token(KIND_AMP, ERR_NONE, byte_pos, length_t'(1));
            else if (c == "|")
                add_token(KIND_PIPE, ERR_NONE, byte_pos, length_t'(1));
            else if (op_index >= 0)
            begin
                held_op = 3'(op_index);
                open_token(SCAN_OPER, c);
            end
            else
                add_token(KIND_ERROR, ERR_UNEXPECTED, byte_pos, length_t'(1));
        end

        // end of source restarts the offset at zero
        if (c != CHAR_NUL)
            byte_pos++;
        if (step_tokens > 0)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic push_word(logic [7:0] value, bit no_gap = 1'b0, bit wait_drain = 1'b0);
        source_word_t w;
        w.value      = value;
        w.no_gap     = no_gap;
        w.wait_drain = wait_drain;
        source_words.push_back(w);
        if (!no_gap)
            gapped_words++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(s[i]);
    endtask

    function automatic logic [7:0] random_ident_char(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] random_digit(int lowest);
        return 8'("0" + $urandom_range(lowest, 9));
    endfunction

    // One random token, mostly well formed, sometimes glued to the next one
    task automatic push_random_token();
        int    pick;
        int    n;
        string kw;
        pick = $urandom_range(0, 99);
        kw   = keyword_text[$urandom_range(0, NUM_KEYWORDS - 1)];
        if (pick < 18)
            push_text(kw);
        else if (pick < 26)
        begin
            // near miss: a keyword prefix or a keyword with more characters
            if ($urandom_range(0, 1))
                push_text(kw.substr(0, $urandom_range(0, kw.len() - 2)));
            else
            begin
                push_text(kw);
                repeat ($urandom_range(1, 2)) push_word(random_ident_char(1'b0));
            end
        end
        else if (pick < 38)
        begin
            push_word(random_ident_char(1'b1));
            repeat ($urandom_range(0, 6)) push_word(random_ident_char(1'b0));
        end
        else if (pick < 48)
        begin
            // a leading zero ends the number, so "0" plus digits splits in two
            push_word($urandom_range(0, 3) == 0 ? "0" : random_digit(1));
            repeat ($urandom_range(0, 5)) push_word(random_digit(0));
        end
        else if (pick < 56)
        begin
            push_word(random_digit(0));
            repeat ($urandom_range(0, 3)) push_word(random_digit(0));
            push_word(".");
            // one in four leaves the fraction out
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 3)) push_word(random_digit(0));
        end
        else if (pick < 72)
        begin
            n = $urandom_range(0, 11);
            if (n < 7)
            begin
                push_word(op_text[n]);
                if ($urandom_range(0, 1))
                    push_word("=");
            end
            else
                push_word(punct_text[n - 7]);
        end
        else if (pick < 80)
            push_word(CHAR_LF);
        else if (pick < 87)
        begin
            n = $urandom_range(0, 2);
            push_word(n == 0 ? " " : (n == 1 ? CHAR_TAB : CHAR_CR));
        end
        else if (pick < 97)
            push_word(8'($urandom_range(1, 255)));
        else
            push_word(CHAR_NUL);
        if ($urandom_range(0, 2) != 0)
            push_word(" ");
    endtask

    // Idle length for either side; some stretches run with no idling at all
    function automatic int pick_idle();
        int r;
        if (cycle_count[8:7] == 2'b00)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, MAX_IDLE);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string detail);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns token %0d: %s", $realtime, tokens_checked, detail);
        mismatch_count++;
    endtask

    task automatic compare_token(token_t got, token_t want);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("token_kind %0d, expected %0d", got.kind, want.kind));
        if (got.err !== want.err)
            report_mismatch($sformatf("error_code %0d, expected %0d", got.err, want.err));
        if (got.offset !== want.offset)
            report_mismatch($sformatf("token_offset %0d, expected %0d", got.offset, want.offset));
        if (got.length !== want.length)
            report_mismatch($sformatf("token_length %0d, expected %0d", got.length, want.length));
        if (got.line !== want.line)
            report_mismatch($sformatf("token_line %0d, expected %0d", got.line, want.line));
        if (got.last !== want.last)
            report_mismatch($sformatf("last_of_run %0d, expected %0d", got.last, want.last));
    endtask

    // Token monitor and source word observer, both sampled at the rising edge
    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        if (rst_n)
        begin
            if (token_bus.valid && token_bus.ready)
            begin
                got.kind   = token_bus.token_kind;
                got.err    = token_bus.error_code;
                got.offset = token_bus.token_offset;
                got.length = token_bus.token_length;
                got.line   = token_bus.token_line;
                got.last   = token_bus.last_of_run;
                if (expected_tokens.size() == 0)
                    report_mismatch($sformatf("token of kind %0d with none expected", got.kind));
                else
                begin
                    want = expected_tokens.pop_front();
                    compare_token(got, want);
                    if (want.kind >= KIND_KW_BASE && want.kind < KIND_INT)
                        keywords_seen++;
                    if (want.kind == KIND_FLOAT)
                        floats_seen++;
                    if (want.kind == KIND_ERROR)
                        errors_seen++;
                    if (want.kind == KIND_EOF)
                        eofs_seen++;
                end
                tokens_checked++;
            end
            if (byte_bus.valid && byte_bus.ready)
            begin
                scan_word(byte_bus.source_byte);
                word_taken = 1'b1;
                words_in++;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // Source driver: presents queued words at the falling edge
    always @(negedge clk)
    begin
        source_word_t w;
        logic         next_valid;
        next_valid = byte_bus.valid;
        if (word_taken)
        begin
            next_valid = 1'b0;
            word_taken = 1'b0;
        end
        // keep offering while the output is held off, so the block backs up
        if (hold_left > 0)
            gap_left = 0;
        if (rst_n && !next_valid)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (source_words.size() > 0 &&
                     (!source_words[0].wait_drain || expected_tokens.size() == 0))
            begin
                w = source_words.pop_front();
                byte_bus.source_byte <= w.value;
                next_valid = 1'b1;
                gap_left   = w.no_gap ? 0 : pick_idle();
            end
        end
        byte_bus.valid <= next_valid;
    end

    // Token sink: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        logic next_ready;
        if (!rst_n || hold_left > 0)
            next_ready = 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            next_ready = 1'b0;
        end
        else
        begin
            next_ready = 1'b1;
            stall_left = pick_idle();
        end
        token_bus.ready <= next_ready;
    end

    // Long output hold-off, started once a set number of words has gone in
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_bus.valid && byte_bus.ready)
                hold_words_seen++;
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && hold_words_seen >= hold_at)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_limit > 0 && cycle_count >= cycle_limit)
        begin
            $display("Timeout after %0d cycles, %0d tokens outstanding", cycle_count,
                     expected_tokens.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        string head;
        int    random_start;
        bit    drain_placed;
        head         = "while";
        drain_placed = 1'b0;

        rst_n                = 1'b0;
        byte_bus.valid       = 1'b0;
        byte_bus.source_byte = '0;
        token_bus.ready      = 1'b0;
        reset_scanner();

        // Directed: leading zero, float, missing fraction, lone dot, "==", operators with
        // and without '=', blanks, a high byte, and a zero byte right after a dot
        push_text("0.5 012 7.if .(==&|)");
        push_word(CHAR_LF);
        push_text("<=+");
        push_word(CHAR_TAB);
        push_word(CHAR_CR);
        push_word(8'hFF);
        push_text("9.");
        push_word(CHAR_NUL);

        // A long identifier that starts like a keyword, sent back to back
        for (int i = 0; i < LONG_IDENT_LEN; i++)
            push_word(i < head.len() ? head[i] : random_ident_char(1'b0), 1'b1, i == 0);
        push_word(" ");

        // Random token stream, with one pause for the output to drain halfway
        random_start = source_words.size();
        hold_at      = random_start + 150;
        while (source_words.size() - random_start < RANDOM_WORDS)
        begin
            if (!drain_placed && source_words.size() - random_start >= RANDOM_WORDS / 2)
            begin
                push_word(" ", 1'b0, 1'b1);
                drain_placed = 1'b1;
            end
            push_random_token();
        end
        push_word(CHAR_NUL);

        cycle_limit = 4 * (source_words.size() + gapped_words * (MAX_IDLE + 2 * (MAX_IDLE + 4))
                           + HOLD_CYCLES + 1000);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (source_words.size() != 0 || byte_bus.valid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Scanned %0d source words into %0d tokens: %0d keywords, %0d floats, %0d errors,",
                 words_in, tokens_checked, keywords_seen, floats_seen, errors_seen);
        $display("%0d ends of source, one %0d-word identifier and a %0d-cycle output hold-off.",
                 eofs_seen, LONG_IDENT_LEN, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
